// ===== sv/sdse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sdse_pkg;

    localparam int POS_W    = 8;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [POS_W-1:0] NO_BASELINE   = 8'd255;
    localparam logic [POS_W-1:0] MIN_THRESHOLD = 8'd4;
    localparam logic [POS_W-1:0] THR_RESET     = 8'd6;

    // register index, taken from paddr[2]
    localparam logic REG_STEP_THRESHOLD = 1'b0;

    typedef struct packed {
        logic             touched;
        logic [POS_W-1:0] position;
    } in_t;

    typedef struct packed {
        logic direction;
        logic last_click;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_NEG,
        S_TEST,
        S_STEP,
        S_SEND
    } state_t;

endpackage

`default_nettype wire

// ===== sv/sdse_sub.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdse_sub (
    input  wire logic [sdse_pkg::POS_W-1:0] a,
    input  wire logic [sdse_pkg::POS_W-1:0] b,
    output logic      [sdse_pkg::POS_W-1:0] diff,
    output logic                            borrow
);
    import sdse_pkg::*;

    logic [POS_W:0] full;

    // borrow set means a < b
    assign full   = {1'b0, a} - {1'b0, b};
    assign diff   = full[POS_W-1:0];
    assign borrow = full[POS_W];

endmodule

`default_nettype wire

// ===== sv/slider_delta_step_encoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Slider delta step encoder. Each input beat is one poll sample (touched flag and 8-bit
// position); each output beat is one volume click (direction, last_click). All arithmetic
// runs through a single 8-bit subtractor under a small sequencer, and in_ready is high only
// while the sequencer is idle. A released sample, or one that sets a new baseline, passes
// through S_CHECK alone; a touched sample with a change below step_threshold adds S_TEST
// (rise) or S_NEG and S_TEST (fall); a sample that makes n clicks then runs S_STEP and
// S_SEND per click (the subtractor removing one threshold each), S_SEND holding while
// out_ready is low. step_threshold is at APB byte address 0; values below 4 act as 4.
module slider_delta_step_encoder_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire sdse_pkg::in_t                    in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output sdse_pkg::out_t                        out_data,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [sdse_pkg::APB_AW-1:0]      paddr,
    input  wire logic [sdse_pkg::APB_DW-1:0]      pwdata,
    output logic      [sdse_pkg::APB_DW-1:0]      prdata,
    output logic                                  pready
);
    import sdse_pkg::*;

    state_t           state_reg, state_next;
    logic [POS_W-1:0] thr_reg;
    logic [POS_W-1:0] thr_eff;
    logic [POS_W-1:0] baseline_reg;
    logic [POS_W-1:0] rem_reg;
    logic [POS_W-1:0] pos_reg;
    logic             touched_reg;
    logic             dir_reg;
    logic             last_reg;

    logic [POS_W-1:0] op_a, op_b, diff;
    logic             borrow;

    sdse_sub u_sub (
        .a      (op_a),
        .b      (op_b),
        .diff   (diff),
        .borrow (borrow)
    );

    assign thr_eff = (thr_reg < MIN_THRESHOLD) ? MIN_THRESHOLD : thr_reg;

    // APB
    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_STEP_THRESHOLD)
        begin
            prdata[POS_W-1:0] = thr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_STEP_THRESHOLD)
        begin
            thr_reg <= pwdata[POS_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!touched_reg || baseline_reg == NO_BASELINE)
                begin
                    state_next = S_IDLE;
                end
                else if (borrow)
                begin
                    state_next = S_NEG;
                end
                else
                begin
                    state_next = S_TEST;
                end
            end
            S_NEG:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                state_next = borrow ? S_IDLE : S_STEP;
            end
            S_STEP:
            begin
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (out_ready)
                begin
                    state_next = last_reg ? S_IDLE : S_STEP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and subtractor operands
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        op_a      = rem_reg;
        op_b      = thr_eff;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_CHECK:
            begin
                op_a = pos_reg;
                op_b = baseline_reg;
            end
            S_NEG:
            begin
                op_a = baseline_reg;
                op_b = pos_reg;
            end
            S_TEST, S_STEP:
            begin
                op_a = rem_reg;
                op_b = thr_eff;
            end
            S_SEND:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign out_data = '{direction: dir_reg, last_click: last_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            baseline_reg <= NO_BASELINE;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CHECK)
            begin
                if (!touched_reg)
                begin
                    baseline_reg <= NO_BASELINE;
                end
                else if (baseline_reg == NO_BASELINE)
                begin
                    baseline_reg <= pos_reg;
                end
            end
            else if (state_reg == S_TEST && !borrow)
            begin
                // at least one click: nothing reads the baseline until idle
                baseline_reg <= pos_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    touched_reg <= in_data.touched;
                    pos_reg     <= in_data.position;
                end
            end
            S_CHECK:
            begin
                dir_reg <= borrow;
                rem_reg <= diff;
            end
            S_NEG:
            begin
                rem_reg <= diff;
            end
            S_TEST:
            begin
                // remainder after the first click
                rem_reg <= diff;
            end
            S_STEP:
            begin
                last_reg <= borrow;
                if (!borrow)
                begin
                    rem_reg <= diff;
                end
            end
            S_SEND:
            begin
                last_reg <= last_reg;
            end
            default:
            begin
                last_reg <= last_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/sdse_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdse_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_ready,
    input  wire logic           out_valid,
    input  wire logic           out_ready,
    input  wire sdse_pkg::out_t out_data
);
    import sdse_pkg::*;

    // never take a sample while a click is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready and out_valid both high");

    // a taken sample keeps the block busy, so in_ready drops right after the input beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready high right after an input beat");

    // more clicks follow a non-final click, so stay busy
    a_busy_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_data.last_click) |=> !in_ready)
        else $error("in_ready high inside a click burst");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled output beat changed");

endmodule

bind slider_delta_step_encoder_core sdse_checker u_sdse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
